// ===== sv/tccc_pkg.sv =====
// Shared types, codes and the palette for the text console cursor controller.
package tccc_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 9;
  localparam int QueueDepth    = 4;

  localparam int DefaultMaxCols = 256;
  localparam int DefaultMaxRows = 256;

  localparam logic [CfgIndexWidth-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MUTED    = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_COLS     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ROWS     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_FG_INDEX = 3'd4;

  localparam logic [6:0] GLYPH_SPACE = 7'h20;
  localparam logic [7:0] CODE_FIRST  = 8'h20;
  localparam logic [7:0] CODE_LAST   = 8'h7E;
  localparam logic [7:0] CODE_BS     = 8'd8;
  localparam logic [7:0] CODE_TAB    = 8'd9;
  localparam logic [7:0] CODE_NL     = 8'd10;
  localparam logic [7:0] CODE_CR     = 8'd13;
  localparam logic [23:0] COLOR_BLACK = 24'h000000;

  typedef enum logic [2:0] {
    CMD_ERASE  = 3'd0,
    CMD_GLYPH  = 3'd1,
    CMD_SCROLL = 3'd2,
    CMD_ULINE  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_PRINT = 3'd0,
    KIND_NL    = 3'd1,
    KIND_CR    = 3'd2,
    KIND_TAB   = 3'd3,
    KIND_BS    = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] glyph;
  } req_t;

  typedef struct packed {
    logic       enable;
    logic       muted;
    logic [8:0] cols;
    logic [8:0] rows;
    logic [3:0] fg_index;
  } cfg_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] c;
    unique case (idx)
      4'd0:  c = 24'h000000;
      4'd1:  c = 24'h0000AA;
      4'd2:  c = 24'h00AA00;
      4'd3:  c = 24'h00AAAA;
      4'd4:  c = 24'hAA0000;
      4'd5:  c = 24'hAA00AA;
      4'd6:  c = 24'hAA5500;
      4'd7:  c = 24'hAAAAAA;
      4'd8:  c = 24'h555555;
      4'd9:  c = 24'h5555FF;
      4'd10: c = 24'h55FF55;
      4'd11: c = 24'h55FFFF;
      4'd12: c = 24'hFF5555;
      4'd13: c = 24'hFF55FF;
      4'd14: c = 24'hFFFF55;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/text_console_cursor_controller.sv =====
// Text console cursor controller: turns character and clear requests into cell commands.
//
// Input channel (in_valid/in_stall, req_type, char_code): one request per
// transfer. A clear request gives one clear command; a character request gives
// an optional underline erase, an optional glyph draw, an optional scroll and
// an underline draw, so one to four commands. Requests made while disabled, or
// character requests while muted, give no commands and are simply consumed.
// Output channel (out_valid/out_stall, cmd..last): one command per transfer,
// last marks the final command of a request.
// The front end takes a request every cycle while its 4-entry queue has room;
// the sequencer issues one command per cycle from a single output register
// while the output does not stall. When the queue is empty, a request passes
// the queue and the pending-command register before its first command is
// registered in the output. A stalled output holds its command and the
// sequencer waits; the queue keeps taking requests until full, then in_stall rises.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// writing cols or rows homes the cursor. Reset restores the register defaults
// (disabled, 80x25, color index 7), homes the cursor and empties the queue.
module text_console_cursor_controller #(
  parameter int MAX_COLS = tccc_pkg::DefaultMaxCols,
  parameter int MAX_ROWS = tccc_pkg::DefaultMaxRows
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tccc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tccc_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic [7:0]                         char_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         cmd,
  output logic [7:0]                         col,
  output logic [7:0]                         row,
  output logic [6:0]                         glyph,
  output logic [23:0]                        color,
  output logic                               last
);
  import tccc_pkg::*;

  cfg_t cfg;
  logic geom_write;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  req_t f_entry;
  req_t q_entry;

  assign cfg_ready  = 1'b1;
  assign in_stall   = q_full;
  assign geom_write = cfg_valid && (cfg_index == REG_COLS || cfg_index == REG_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= 1'b0;
      cfg.muted    <= 1'b0;
      cfg.cols     <= 9'd80;
      cfg.rows     <= 9'd25;
      cfg.fg_index <= 4'd7;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:   cfg.enable   <= cfg_data[0];
        REG_MUTED:    cfg.muted    <= cfg_data[0];
        REG_COLS:     cfg.cols     <= cfg_data;
        REG_ROWS:     cfg.rows     <= cfg_data;
        REG_FG_INDEX: cfg.fg_index <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  tccc_front u_front (
    .valid     (in_valid && !q_full),
    .req_type  (req_type),
    .char_code (char_code),
    .cfg       (cfg),
    .push      (q_push),
    .entry     (f_entry)
  );

  tccc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (f_entry),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rd_entry (q_entry)
  );

  tccc_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .geom_write (geom_write),
    .q_nonempty (q_nonempty),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .col        (col),
    .row        (row),
    .glyph      (glyph),
    .color      (color),
    .last       (last)
  );

endmodule

// ===== sv/tccc_front.sv =====
// Request front end: filters by enable/muted and classifies the character code.
module tccc_front (
  input  logic              valid,
  input  logic              req_type,
  input  logic [7:0]        char_code,
  input  tccc_pkg::cfg_t    cfg,
  output logic              push,
  output tccc_pkg::req_t    entry
);
  import tccc_pkg::*;

  always_comb begin
    entry.glyph = GLYPH_SPACE;
    if (req_type) begin
      entry.kind = KIND_CLEAR;
    end else begin
      priority if (char_code == CODE_NL) begin
        entry.kind = KIND_NL;
      end else if (char_code == CODE_CR) begin
        entry.kind = KIND_CR;
      end else if (char_code == CODE_TAB) begin
        entry.kind = KIND_TAB;
      end else if (char_code == CODE_BS) begin
        entry.kind = KIND_BS;
      end else begin
        entry.kind = KIND_PRINT;
        // map anything outside the printable range to space
        if (char_code >= CODE_FIRST && char_code <= CODE_LAST) begin
          entry.glyph = char_code[6:0];
        end
      end
    end
  end

  // drop requests that would produce nothing
  assign push = valid && cfg.enable && (req_type || !cfg.muted);

endmodule

// ===== sv/tccc_queue.sv =====
// Short request queue between the front end and the command sequencer.
module tccc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tccc_pkg::req_t wr_entry,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output tccc_pkg::req_t rd_entry
);
  import tccc_pkg::*;

  localparam int PtrWidth = $clog2(QueueDepth);

  req_t                mem [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [PtrWidth:0]   count;

  assign full     = (count == (PtrWidth+1)'(QueueDepth));
  assign nonempty = (count != '0);
  assign rd_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && nonempty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push && !full, pop && nonempty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/tccc_back.sv =====
// Command sequencer: owns the cursor and issues one cell command per cycle unless stalled.
module tccc_back #(
  parameter int MAX_COLS = tccc_pkg::DefaultMaxCols,
  parameter int MAX_ROWS = tccc_pkg::DefaultMaxRows
) (
  input  logic           clk,
  input  logic           rst,
  input  tccc_pkg::cfg_t cfg,
  input  logic           geom_write,
  input  logic           q_nonempty,
  input  tccc_pkg::req_t q_entry,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     cmd,
  output logic [7:0]     col,
  output logic [7:0]     row,
  output logic [6:0]     glyph,
  output logic [23:0]    color,
  output logic           last
);
  import tccc_pkg::*;

  localparam int ColLimInt = (MAX_COLS < 256) ? ((MAX_COLS < 1) ? 1 : MAX_COLS) : 256;
  localparam int RowLimInt = (MAX_ROWS < 256) ? ((MAX_ROWS < 1) ? 1 : MAX_ROWS) : 256;
  localparam logic [8:0] COL_LIM = 9'(ColLimInt);
  localparam logic [8:0] ROW_LIM = 9'(RowLimInt);

  // pending command bits, issued lowest first
  localparam int P_ERASE  = 0;
  localparam int P_GLYPH  = 1;
  localparam int P_SCROLL = 2;
  localparam int P_ULINE  = 3;
  localparam int P_CLEAR  = 4;

  logic [7:0]  cur_col;
  logic [7:0]  cur_row;
  logic        shown;

  logic [4:0]  pend;
  logic [4:0]  pend_next;
  logic [7:0]  e_col;
  logic [7:0]  e_row;
  logic [7:0]  g_col;
  logic [7:0]  g_row;
  logic [6:0]  g_code;
  logic [7:0]  u_col;
  logic [7:0]  u_row;
  logic [23:0] fg;

  logic [8:0]  ncols;
  logic [8:0]  nrows;
  logic [8:0]  c9;
  logic [8:0]  r9;
  logic [8:0]  c_step;
  logic [8:0]  r_step;
  logic [8:0]  r_wr;
  logic [8:0]  r_fin;
  logic [8:0]  c_fin;
  logic        gl_en;
  logic [7:0]  gl_col;
  logic [6:0]  gl_code;
  logic        scroll;
  logic        is_clear;

  logic [4:0]  sel;
  logic        emit;
  logic        only_one;

  always_comb begin
    ncols = (cfg.cols == '0) ? 9'd1 : ((cfg.cols > COL_LIM) ? COL_LIM : cfg.cols);
    nrows = (cfg.rows == '0) ? 9'd1 : ((cfg.rows > ROW_LIM) ? ROW_LIM : cfg.rows);
  end

  // work out the new cursor for the request at the queue head
  always_comb begin
    is_clear = (q_entry.kind == KIND_CLEAR);
    c9       = {1'b0, cur_col};
    r9       = {1'b0, cur_row};
    c_step   = c9;
    r_step   = r9;
    gl_en    = 1'b0;
    gl_col   = cur_col;
    gl_code  = GLYPH_SPACE;
    unique case (q_entry.kind)
      KIND_NL: begin
        c_step = '0;
        r_step = r9 + 9'd1;
      end
      KIND_CR: begin
        c_step = '0;
      end
      KIND_TAB: begin
        c_step = (c9 + 9'd4) & ~9'd3;
      end
      KIND_BS: begin
        // nothing to blank at the left edge
        if (cur_col != '0) begin
          c_step = c9 - 9'd1;
          gl_en  = 1'b1;
          gl_col = cur_col - 8'd1;
        end
      end
      KIND_PRINT: begin
        gl_en   = 1'b1;
        gl_code = q_entry.glyph;
        c_step  = c9 + 9'd1;
      end
      default: begin
      end
    endcase
    if (c_step >= ncols) begin
      c_fin = '0;
      r_wr  = r_step + 9'd1;
    end else begin
      c_fin = c_step;
      r_wr  = r_step;
    end
    scroll = (r_wr >= nrows);
    r_fin  = scroll ? (nrows - 9'd1) : r_wr;
  end

  always_comb begin
    priority if (pend[P_ERASE]) begin
      sel = 5'b00001;
    end else if (pend[P_GLYPH]) begin
      sel = 5'b00010;
    end else if (pend[P_SCROLL]) begin
      sel = 5'b00100;
    end else if (pend[P_ULINE]) begin
      sel = 5'b01000;
    end else if (pend[P_CLEAR]) begin
      sel = 5'b10000;
    end else begin
      sel = 5'b00000;
    end
    emit     = (pend != '0) && (!out_valid || !out_stall);
    only_one = ((pend & ~sel) == '0);
    q_pop    = q_nonempty && ((pend == '0) || (emit && only_one));
    pend_next = emit ? (pend & ~sel) : pend;
    if (q_pop) begin
      if (is_clear) begin
        pend_next = 5'b10000;
      end else begin
        pend_next = {1'b0, 1'b1, scroll, gl_en, shown};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      shown   <= 1'b0;
      pend    <= '0;
    end else begin
      pend <= pend_next;
      if (geom_write) begin
        cur_col <= '0;
        cur_row <= '0;
        shown   <= 1'b0;
      end else if (q_pop) begin
        if (is_clear) begin
          cur_col <= '0;
          cur_row <= '0;
          shown   <= 1'b0;
        end else begin
          cur_col <= c_fin[7:0];
          cur_row <= r_fin[7:0];
          shown   <= 1'b1;
        end
      end
    end
  end

  // hold the command fields of the request being issued
  always_ff @(posedge clk) begin
    if (q_pop) begin
      e_col  <= cur_col;
      e_row  <= cur_row;
      g_col  <= gl_col;
      g_row  <= cur_row;
      g_code <= gl_code;
      u_col  <= c_fin[7:0];
      u_row  <= r_fin[7:0];
      fg     <= palette(cfg.fg_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      last  <= only_one;
      glyph <= GLYPH_SPACE;
      col   <= '0;
      row   <= '0;
      color <= COLOR_BLACK;
      unique case (1'b1)
        sel[P_ERASE]: begin
          cmd <= CMD_ERASE;
          col <= e_col;
          row <= e_row;
        end
        sel[P_GLYPH]: begin
          cmd   <= CMD_GLYPH;
          col   <= g_col;
          row   <= g_row;
          glyph <= g_code;
          color <= fg;
        end
        sel[P_SCROLL]: begin
          cmd <= CMD_SCROLL;
        end
        sel[P_ULINE]: begin
          cmd   <= CMD_ULINE;
          col   <= u_col;
          row   <= u_row;
          color <= fg;
        end
        default: begin
          cmd <= CMD_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== tb/tccc_cmd_checker.sv =====
// Checker: tracks cursor state from observed transfers and compares every cell command.
module tccc_cmd_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [tccc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [tccc_pkg::CfgDataWidth-1:0]  cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               req_type,
  input  logic [7:0]                         char_code,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [2:0]                         cmd,
  input  logic [7:0]                         col,
  input  logic [7:0]                         row,
  input  logic [6:0]                         glyph,
  input  logic [23:0]                        color,
  input  logic                               last,
  output int                                 mismatches,
  output int                                 cmds_pending,
  output int                                 cmds_checked
);
  import tccc_pkg::*;

  typedef struct packed {
    cmd_t        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [6:0]  glyph;
    logic [23:0] rgb;
    logic        last;
  } cell_cmd_t;

  logic       en_q, mute_q;
  logic [8:0] cols_q, rows_q;
  logic [3:0] fg_q;
  logic [7:0] cur_col, cur_row;
  logic       uline_on;
  cell_cmd_t  cmds_due[$];
  cell_cmd_t  due;
  int         n_bad = 0;
  int         n_checked = 0;

  // 16-color text palette: bit 3 adds intensity, index 6 is brown rather than dark yellow.
  function automatic logic [23:0] fg_rgb(input logic [3:0] idx);
    logic [7:0] lo, hi, g;
    lo = idx[3] ? 8'h55 : 8'h00;
    hi = lo + 8'hAA;
    g  = (idx == 4'd6) ? 8'h55 : (idx[1] ? hi : lo);
    return {idx[2] ? hi : lo, g, idx[0] ? hi : lo};
  endfunction

  function automatic int span(input logic [8:0] v, input int bound);
    int lim;
    lim = (bound < 256) ? bound : 256;
    if (lim < 1) lim = 1;
    if (v == 0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic cell_cmd_t make_cmd(input cmd_t k, input int c, input int r,
                                         input logic [6:0] g, input logic [23:0] rgb);
    cell_cmd_t t;
    t.kind  = k;
    t.col   = c[7:0];
    t.row   = r[7:0];
    t.glyph = g;
    t.rgb   = rgb;
    t.last  = 1'b0;
    return t;
  endfunction

  task automatic model_request(input logic clr, input logic [7:0] code);
    cell_cmd_t   burst[$];
    cell_cmd_t   t;
    int          c, r, ncols, nrows;
    logic [23:0] fg;
    logic [6:0]  g;
    fg    = fg_rgb(fg_q);
    ncols = span(cols_q, DefaultMaxCols);
    nrows = span(rows_q, DefaultMaxRows);
    if (!en_q) begin
      // drop: disabled console swallows every request
    end else if (clr) begin
      burst.push_back(make_cmd(CMD_CLEAR, 0, 0, GLYPH_SPACE, COLOR_BLACK));
      cur_col  = '0;
      cur_row  = '0;
      uline_on = 1'b0;
    end else if (!mute_q) begin
      c = int'(cur_col);
      r = int'(cur_row);
      if (uline_on) begin
        uline_on = 1'b0;
        burst.push_back(make_cmd(CMD_ERASE, c, r, GLYPH_SPACE, COLOR_BLACK));
      end
      if (code == CODE_NL) begin
        c = 0;
        r++;
      end else if (code == CODE_CR) begin
        c = 0;
      end else if (code == CODE_TAB) begin
        c = (c + 4) & ~3;
      end else if (code == CODE_BS) begin
        if (c > 0) begin
          c--;
          burst.push_back(make_cmd(CMD_GLYPH, c, r, GLYPH_SPACE, fg));
        end
      end else begin
        g = (code < CODE_FIRST || code > CODE_LAST) ? GLYPH_SPACE : code[6:0];
        burst.push_back(make_cmd(CMD_GLYPH, c, r, g, fg));
        c++;
      end
      if (c >= ncols) begin
        c = 0;
        r++;
      end
      if (r >= nrows) begin
        burst.push_back(make_cmd(CMD_SCROLL, 0, 0, GLYPH_SPACE, COLOR_BLACK));
        r = nrows - 1;
      end
      burst.push_back(make_cmd(CMD_ULINE, c, r, GLYPH_SPACE, fg));
      uline_on = 1'b1;
      cur_col  = c[7:0];
      cur_row  = r[7:0];
    end
    foreach (burst[i]) begin
      t      = burst[i];
      t.last = (i == burst.size() - 1);
      cmds_due.push_back(t);
    end
  endtask

  task automatic cmp(input string name, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      en_q     = 1'b0;
      mute_q   = 1'b0;
      cols_q   = 9'd80;
      rows_q   = 9'd25;
      fg_q     = 4'd7;
      cur_col  = '0;
      cur_row  = '0;
      uline_on = 1'b0;
      cmds_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (cmds_due.size() == 0) begin
          $error("cell command %0d at col %0d row %0d with nothing expected", cmd, col, row);
          n_bad++;
        end else begin
          due = cmds_due.pop_front();
          cmp("cmd", 24'(due.kind), 24'(cmd));
          cmp("col", 24'(due.col), 24'(col));
          cmp("row", 24'(due.row), 24'(row));
          cmp("glyph", 24'(due.glyph), 24'(glyph));
          cmp("color", due.rgb, color);
          cmp("last", 24'(due.last), 24'(last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:   en_q = cfg_data[0];
          REG_MUTED:    mute_q = cfg_data[0];
          REG_COLS: begin
            cols_q   = cfg_data;
            cur_col  = '0;
            cur_row  = '0;
            uline_on = 1'b0;
          end
          REG_ROWS: begin
            rows_q   = cfg_data;
            cur_col  = '0;
            cur_row  = '0;
            uline_on = 1'b0;
          end
          REG_FG_INDEX: fg_q = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) model_request(req_type, char_code);
    end
    mismatches   <= n_bad;
    cmds_pending <= cmds_due.size();
    cmds_checked <= n_checked;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: stimulus for the text console cursor controller and the final verdict.
module tb_top;
  import tccc_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 20;
  localparam int MixGeneral   = 0;
  localparam int MixRows      = 1;
  localparam int MixCols      = 2;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic                     req_type  = 1'b0;
  logic [7:0]               char_code = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               cmd;
  logic [7:0]               col;
  logic [7:0]               row;
  logic [6:0]               glyph;
  logic [23:0]              color;
  logic                     last;

  int gap_pct       = 0;
  int stall_pct     = 0;
  int reqs_sent     = 0;
  int settings_used = 0;
  int quiet         = 0;
  int mismatches, cmds_pending, cmds_checked;

  always #10 clk = ~clk;

  text_console_cursor_controller dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .req_type, .char_code,
    .out_valid, .out_stall, .cmd, .col, .row, .glyph, .color, .last
  );

  tccc_cmd_checker cmd_check (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .req_type, .char_code,
    .out_valid, .out_stall, .cmd, .col, .row, .glyph, .color, .last,
    .mismatches, .cmds_pending, .cmds_checked
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // End the run when no channel has moved a transfer for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic en, input logic mu, input logic [8:0] cw,
                           input logic [8:0] rh, input logic [3:0] fg);
    logic [8:0] noise;
    noise = 9'($urandom);
    write_reg(REG_ENABLE, {noise[8:1], en});
    noise = 9'($urandom);
    write_reg(REG_MUTED, {noise[8:1], mu});
    write_reg(REG_COLS, cw);
    write_reg(REG_ROWS, rh);
    noise = 9'($urandom);
    write_reg(REG_FG_INDEX, {noise[8:4], fg});
    settings_used++;
  endtask

  task automatic send_req(input logic clr, input logic [7:0] code);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid  <= 1'b1;
    req_type  <= clr;
    char_code <= code;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (cmds_pending != 0);
  endtask

  // Hold off long enough after draining for the design to go idle.
  task automatic settle();
    drain();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_idle(input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  task automatic run_random(input int count, input int mix);
    int         roll;
    logic [7:0] code;
    logic       clr;
    repeat (count) begin
      roll = $urandom_range(99);
      code = 8'($urandom);
      clr  = 1'b0;
      case (mix)
        MixRows: begin
          if (roll < 85) code = CODE_NL;
          else if (roll < 93) code = 8'($urandom_range(CODE_LAST, CODE_FIRST));
        end
        MixCols: begin
          if (roll < 65) code = CODE_TAB;
          else if (roll < 70) code = CODE_BS;
          else if (roll < 95) code = 8'($urandom_range(CODE_LAST, CODE_FIRST));
        end
        default: begin
          if (roll < 5) clr = 1'b1;
          else if (roll < 15) code = CODE_NL;
          else if (roll < 23) code = CODE_CR;
          else if (roll < 32) code = CODE_TAB;
          else if (roll < 40) code = CODE_BS;
          else if (roll < 80) code = 8'($urandom_range(CODE_LAST, CODE_FIRST));
        end
      endcase
      send_req(clr, code);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Console comes out of reset disabled: these must produce nothing.
    send_req(1'b1, 8'($urandom));
    send_req(1'b0, 8'h41);
    settle();

    configure(1'b1, 1'b0, 9'd8, 9'd3, 4'd15);
    for (int i = REG_FG_INDEX + 1; i < 8; i++) write_reg(i[2:0], 9'($urandom));

    send_req(1'b1, 8'($urandom));
    send_req(1'b0, CODE_BS);
    send_req(1'b0, 8'h41);
    send_req(1'b0, 8'h00);
    send_req(1'b0, 8'hFF);
    send_req(1'b0, CODE_LAST);
    send_req(1'b0, CODE_FIRST);
    send_req(1'b0, 8'h1F);
    send_req(1'b0, 8'h7F);
    send_req(1'b0, 8'h80);
    send_req(1'b0, CODE_TAB);
    send_req(1'b0, CODE_TAB);
    send_req(1'b0, 8'h78);
    send_req(1'b0, CODE_BS);
    send_req(1'b0, CODE_BS);
    send_req(1'b0, CODE_CR);
    send_req(1'b0, CODE_NL);
    send_req(1'b0, CODE_NL);
    settle();

    // Muted: characters vanish, a clear still goes through.
    configure(1'b1, 1'b1, 9'd8, 9'd3, 4'd0);
    send_req(1'b0, 8'h51);
    send_req(1'b1, 8'($urandom));
    send_req(1'b0, CODE_NL);
    settle();

    // Zero geometry acts as a single cell.
    configure(1'b1, 1'b0, 9'd0, 9'd0, 4'd1);
    send_req(1'b0, 8'h5A);
    send_req(1'b0, CODE_NL);
    send_req(1'b0, CODE_TAB);
    send_req(1'b0, CODE_BS);
    send_req(1'b1, 8'($urandom));
    settle();

    set_idle(0, 0);
    configure(1'b1, 1'b0, 9'd8, 9'd4, 4'($urandom));
    run_random(25, MixGeneral);
    settle();

    set_idle(51, 0);
    configure(1'b1, 1'b0, 9'd0, 9'd2, 4'($urandom));
    run_random(20, MixGeneral);
    settle();

    // Oversized geometry saturates; tabs push the cursor into the high columns.
    set_idle(0, 51);
    configure(1'b1, 1'b0, 9'h1FF, 9'd300, 4'($urandom));
    run_random(80, MixCols);
    settle();

    // Newline-heavy stream to walk the cursor down to a scroll on a tall grid.
    set_idle(37, 37);
    configure(1'b1, 1'b0, 9'd40, 9'd50, 4'($urandom));
    run_random(70, MixRows);
    settle();

    configure(1'b1, 1'b1, 9'd256, 9'd256, 4'd15);
    run_random(10, MixGeneral);
    settle();

    configure(1'b0, 1'b0, 9'd80, 9'd25, 4'd7);
    run_random(5, MixGeneral);
    settle();

    configure(1'b1, 1'b0, 9'd80, 9'd25, 4'd0);
    run_random(6, MixGeneral);
    drain();
    run_random(6, MixGeneral);

    drain();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d requests under %0d register settings; %0d cell commands compared.",
             reqs_sent, settings_used, cmds_checked);
    $display("Covered glyphs, controls, wrap, scroll, muting, disable and geometry extremes.");
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tccc_pkg.sv
sv/tccc_front.sv
sv/tccc_queue.sv
sv/tccc_back.sv
sv/text_console_cursor_controller.sv
tb/tccc_cmd_checker.sv
tb/tb_top.sv
